// File: sv/ghsf_pkg.sv
// ----------------------------------------------------------------------------
// ghsf_pkg
// Shared types and constants of the gaussian half-scale filter.
// ----------------------------------------------------------------------------
`default_nettype none
package ghsf_pkg;
   localparam logic [2:0] CsrSrcWIdx = 3'd0;
   localparam logic [2:0] CsrSrcHIdx = 3'd1;
   localparam logic [2:0] CsrDstWIdx = 3'd2;
   localparam logic [2:0] CsrDstHIdx = 3'd3;
   localparam logic [2:0] CsrModeIdx = 3'd4;

   localparam logic FuncWrite   = 1'b0;
   localparam logic FuncCompute = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_TAPS,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic tap_start;
      logic tap_step;
      logic acc_drain;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic border;
      logic tap_last;
   } status_type;

   function automatic logic [4:0] tap_weight(input logic mode, input logic [2:0] k);
      logic [4:0] w;
      begin
         w = 5'd0;
         if (mode) begin
            case (k)
               3'd0, 3'd4: w = 5'd1;
               3'd1, 3'd3: w = 5'd4;
               3'd2:       w = 5'd6;
               default:    w = 5'd0;
            endcase
         end else begin
            case (k)
               3'd0, 3'd2: w = 5'd1;
               3'd1:       w = 5'd2;
               default:    w = 5'd0;
            endcase
         end
         return w;
      end
   endfunction
endpackage
`default_nettype wire

// File: sv/ghsf_req_if.sv
// ----------------------------------------------------------------------------
// ghsf_req_if
// Request channel: write a source pixel or compute a destination pixel.
// ----------------------------------------------------------------------------
`default_nettype none
interface ghsf_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] src_col;
   logic [7:0] src_row;
   logic [7:0] pixel_in;
   logic [7:0] dst_col;
   logic [7:0] dst_row;
   modport source (output valid, func, src_col, src_row, pixel_in, dst_col, dst_row,
                   input ready);
   modport sink (input valid, func, src_col, src_row, pixel_in, dst_col, dst_row,
                 output ready);
endinterface
`default_nettype wire

// File: sv/ghsf_rsp_if.sv
// ----------------------------------------------------------------------------
// ghsf_rsp_if
// Result channel: one filtered destination pixel.
// ----------------------------------------------------------------------------
`default_nettype none
interface ghsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic [7:0] out_col;
   logic [7:0] out_row;
   logic       border_zeroed;
   modport source (output valid, pixel_out, out_col, out_row, border_zeroed,
                   input ready);
   modport sink (input valid, pixel_out, out_col, out_row, border_zeroed,
                 output ready);
endinterface
`default_nettype wire

// File: sv/gaussian_half_scale_filter_top.sv
// ----------------------------------------------------------------------------
// gaussian_half_scale_filter_top
// Half-scale binomial filter with built-in frame store.
// ----------------------------------------------------------------------------
// pixel write: accepted while idle, no result
// compute: coordinate division, a check state, 9 or 25 store reads (one per
// cycle on the single store port) and a drain state, then the result
// border rows skip the reads; one request in flight at a time
// synchronous reset restores the size and mode registers; the store is not cleared
`default_nettype none
module gaussian_half_scale_filter_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ghsf_req_if.sink        req,
   ghsf_rsp_if.source      rsp,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [8:0] csr_data
);
   import ghsf_pkg::*;

   logic [8:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic       mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd256;
         src_h_ff <= 9'd256;
         dst_w_ff <= 9'd128;
         dst_h_ff <= 9'd128;
         mode_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrSrcWIdx: src_w_ff <= csr_data;
            CsrSrcHIdx: src_h_ff <= csr_data;
            CsrDstWIdx: dst_w_ff <= csr_data;
            CsrDstHIdx: dst_h_ff <= csr_data;
            CsrModeIdx: mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic req_fire, compute_ok, store_wr;
   cmd_type    cmd;
   status_type status;

   assign req_fire   = req.valid && req.ready;
   assign compute_ok = (req.func == FuncCompute) && ({1'b0, req.dst_col} < dst_w_ff)
                       && ({1'b0, req.dst_row} < dst_h_ff);
   assign store_wr   = req_fire && (req.func == FuncWrite);

   ghsf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_compute_ok(compute_ok),
      .rsp_ready     (rsp.ready),
      .status        (status),
      .cmd           (cmd),
      .req_ready     (req.ready),
      .rsp_valid     (rsp.valid)
   );

   ghsf_datapath #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .store_wr     (store_wr),
      .wr_col       (req.src_col),
      .wr_row       (req.src_row),
      .wr_pixel     (req.pixel_in),
      .dst_col      (req.dst_col),
      .dst_row      (req.dst_row),
      .src_w        (src_w_ff),
      .src_h        (src_h_ff),
      .dst_w        (dst_w_ff),
      .dst_h        (dst_h_ff),
      .mode         (mode_ff),
      .pixel_out    (rsp.pixel_out),
      .out_col      (rsp.out_col),
      .out_row      (rsp.out_row),
      .border_zeroed(rsp.border_zeroed)
   );
endmodule
`default_nettype wire

// File: sv/ghsf_ram.sv
// ----------------------------------------------------------------------------
// ghsf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ghsf_ram #(
   parameter int Width = 8,
   parameter int Depth = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// File: sv/ghsf_ctrl.sv
// ----------------------------------------------------------------------------
// ghsf_ctrl
// Controller: sequences division, tap reads and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module ghsf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   input  wire logic                 req_compute_ok,
   input  wire logic                 rsp_ready,
   input  wire ghsf_pkg::status_type status,
   output ghsf_pkg::cmd_type         cmd,
   output logic                      req_ready,
   output logic                      rsp_valid
);
   import ghsf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && req_compute_ok) begin
               cmd.load      = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.border) begin
               state_in = ST_OUT;
            end else begin
               cmd.tap_start = 1'b1;
               state_in      = ST_TAPS;
            end
         end
         ST_TAPS: begin
            cmd.tap_step = 1'b1;
            if (status.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.acc_drain = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: sv/ghsf_datapath.sv
// ----------------------------------------------------------------------------
// ghsf_datapath
// Datapath: coordinate divider, tap walker, frame store and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module ghsf_datapath #(
   parameter int MaxWidth  = 256,
   parameter int MaxHeight = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ghsf_pkg::cmd_type    cmd,
   output ghsf_pkg::status_type      status,
   input  wire logic                 store_wr,
   input  wire logic [7:0]           wr_col,
   input  wire logic [7:0]           wr_row,
   input  wire logic [7:0]           wr_pixel,
   input  wire logic [7:0]           dst_col,
   input  wire logic [7:0]           dst_row,
   input  wire logic [8:0]           src_w,
   input  wire logic [8:0]           src_h,
   input  wire logic [8:0]           dst_w,
   input  wire logic [8:0]           dst_h,
   input  wire logic                 mode,
   output logic [7:0]                pixel_out,
   output logic [7:0]                out_col,
   output logic [7:0]                out_row,
   output logic                      border_zeroed
);
   import ghsf_pkg::*;

   localparam int Depth   = MaxWidth * MaxHeight;
   localparam int AddrW   = $clog2(Depth);
   localparam int ColW    = $clog2(MaxWidth);
   // numerator (2d+1)*src fits 18 bits, quotient 10 bits
   localparam int NumW    = 18;
   localparam int QW      = 10;

   // two restoring dividers run in parallel, one quotient bit a cycle
   logic [NumW-1:0] xrem_ff, xrem_in, yrem_ff, yrem_in;
   logic [QW-1:0]   xq_ff, xq_in, yq_ff, yq_in;
   logic [4:0]      dcnt_ff, dcnt_in;
   logic            dbusy_ff, dbusy_in;
   logic [7:0]      col_ff, row_ff;
   logic [NumW+QW-1:0] xden, yden;
   logic [NumW-1:0] xnum, ynum;

   always_comb begin
      xnum = NumW'({dst_col, 1'b1}) * NumW'(src_w);
      ynum = NumW'({dst_row, 1'b1}) * NumW'(src_h);
      xden = (NumW+QW)'({dst_w, 1'b0}) << dcnt_ff;
      yden = (NumW+QW)'({dst_h, 1'b0}) << dcnt_ff;
      xrem_in  = xrem_ff;
      yrem_in  = yrem_ff;
      xq_in    = xq_ff;
      yq_in    = yq_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      if (cmd.div_start) begin
         xrem_in  = xnum;
         yrem_in  = ynum;
         xq_in    = '0;
         yq_in    = '0;
         dcnt_in  = 5'(QW - 1);
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         if ((NumW+QW)'(xrem_ff) >= xden) begin
            xrem_in = NumW'((NumW+QW)'(xrem_ff) - xden);
            xq_in[dcnt_ff[3:0]] = 1'b1;
         end
         if ((NumW+QW)'(yrem_ff) >= yden) begin
            yrem_in = NumW'((NumW+QW)'(yrem_ff) - yden);
            yq_in[dcnt_ff[3:0]] = 1'b1;
         end
         if (dcnt_ff == 5'd0) begin
            dbusy_in = 1'b0;
         end else begin
            dcnt_in = dcnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else begin
         dbusy_ff <= dbusy_in;
      end
      xrem_ff <= xrem_in;
      yrem_ff <= yrem_in;
      xq_ff   <= xq_in;
      yq_ff   <= yq_in;
      dcnt_ff <= dcnt_in;
      if (cmd.load) begin
         col_ff <= dst_col;
         row_ff <= dst_row;
      end
   end

   assign status.div_done = dbusy_ff && (dcnt_ff == 5'd0);

   logic [QW:0] ylim;
   assign ylim = {2'b00, src_h} - (QW+1)'(2);
   assign status.border = !(yq_ff > 10'd1 && {1'b0, yq_ff} < ylim)
                          || src_h < 9'd3;

   // tap walker
   logic [2:0] kx_ff, kx_in, ky_ff, ky_in;
   logic [2:0] klast;
   assign klast = mode ? 3'd4 : 3'd2;
   assign status.tap_last = (kx_ff == klast) && (ky_ff == klast);

   always_comb begin
      kx_in = kx_ff;
      ky_in = ky_ff;
      if (cmd.tap_start) begin
         kx_in = '0;
         ky_in = '0;
      end else if (cmd.tap_step) begin
         if (kx_ff == klast) begin
            kx_in = '0;
            ky_in = ky_ff + 3'd1;
         end else begin
            kx_in = kx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kx_ff <= kx_in;
      ky_ff <= ky_in;
   end

   logic signed [QW+1:0] tcol, trow;
   logic [2:0] rad;
   logic       tcol_ok;
   assign rad  = mode ? 3'd2 : 3'd1;
   assign tcol = $signed({2'b00, xq_ff}) + $signed({9'd0, kx_ff}) - $signed({9'd0, rad});
   assign trow = $signed({2'b00, yq_ff}) + $signed({9'd0, ky_ff}) - $signed({9'd0, rad});
   assign tcol_ok = (tcol >= 0) && (tcol < $signed({3'b000, src_w}));

   logic [AddrW-1:0] taddr, waddr, addr;
   assign taddr = AddrW'(32'(trow[QW-1:0]) * MaxWidth + 32'(tcol[QW-1:0]));
   assign waddr = AddrW'(32'(wr_row) * MaxWidth + 32'(wr_col));
   assign addr  = store_wr ? waddr : taddr;

   logic [7:0] rd_data;
   ghsf_ram #(.Width(8), .Depth(Depth)) u_store (
      .clock  (clock),
      .wr_en  (store_wr),
      .addr   (addr),
      .wr_data(wr_pixel),
      .rd_data(rd_data)
   );

   // weight is registered so that it lines up with the registered store read
   logic [4:0]  wy, wx;
   logic [9:0]  w_ff, w_in;
   logic        tv_ff;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  pix_ff, pix_in;
   assign wy = tap_weight(mode, ky_ff);
   assign wx = tap_weight(mode, kx_ff);
   assign w_in = tcol_ok ? (10'(wy) * 10'(wx)) : 10'd0;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.tap_start) begin
         acc_in = '0;
      end else if (tv_ff) begin
         acc_in = acc_ff + (16'(w_ff) * 16'(rd_data));
      end
      pix_in = pix_ff;
      if (cmd.acc_drain) begin
         pix_in = mode ? acc_in[15:8] : ((acc_in[15:12] != 4'd0) ? 8'hff : acc_in[11:4]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else begin
         tv_ff <= cmd.tap_step;
      end
      w_ff   <= w_in;
      acc_ff <= acc_in;
      pix_ff <= pix_in;
   end

   assign pixel_out     = status.border ? 8'd0 : pix_ff;
   assign border_zeroed = status.border;
   assign out_col       = col_ff;
   assign out_row       = row_ff;

   logic unused;
   assign unused = ^{xrem_ff[0], yrem_ff[0], reset, ColW, dst_h[0], col_ff[0]};
endmodule
`default_nettype wire
